### src/sbm_pkg.sv
// ----------------------------------------------------------------------------
// sbm_pkg
// shared constants and types of the substring bracket marker
// ----------------------------------------------------------------------------
package sbm_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int TOTAL_W     = 32;

    localparam logic [7:0] OPEN_CHAR  = 8'h28;
    localparam logic [7:0] CLOSE_CHAR = 8'h29;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd1;

    // control from the sequencer to the row of cells
    typedef struct packed {
        logic                   shift;
        logic [MAX_PATTERN-1:0] load;
        logic [7:0]             data;
        logic [MAX_PATTERN-1:0] in_use;
    } sbm_win_ctrl_t;

    // status from the row of cells to the sequencer
    typedef struct packed {
        logic [7:0] head;
        logic       match;
    } sbm_win_stat_t;

endpackage

### src/substring_bracket_marker_top.sv
// ----------------------------------------------------------------------------
// substring_bracket_marker_top
// marks leftmost non-overlapping pattern matches in a byte stream with
// brackets, keeping a saturating match count
//
//   port group   direction  handshake           payload
//   s_*          in         s_valid / s_ready   text_byte, text_end
//   m_*          out        m_valid / m_ready   out_byte, is_bracket, run_last,
//                                               stream_done, match_total
//   cfg_*        in         cfg_wr_en           cfg_index, cfg_wr_data
//
// one result leaves per cycle through the output register unless m_ready
// stalls it; a text byte releases one result, and each bracket adds a result
// to it; an item that releases no result leaves the input ready; after a shorter
// length or at end of text the window drains at one result per cycle, as m_ready allows
// the next item is taken in the cycle its predecessor's last result is loaded,
// or in the cycle after that after end of text
// synchronous active-low reset, no clearing pass; stalls on m_ready hold
// the sequencer and the window in place
// ----------------------------------------------------------------------------
module substring_bracket_marker_top
    import sbm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_text_byte,
    input  logic                  s_text_end,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_is_bracket,
    output logic                  m_run_last,
    output logic                  m_stream_done,
    output logic [TOTAL_W-1:0]    m_match_total
);

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_BYTE,
        PH_CLOSE
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [63:0]            pat_reg, pat_next;
    logic [3:0]             plen_reg, plen_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [CNT_W-1:0]       cd_reg, cd_next;
    logic [TOTAL_W-1:0]     cnt_reg, cnt_next;
    logic                   run_reg, run_next;
    logic                   flush_reg, flush_next;
    logic                   m_valid_reg, m_valid_next;
    logic [7:0]             m_byte_reg, m_byte_next;
    logic                   m_brk_reg, m_brk_next;
    logic                   m_last_reg, m_last_next;
    logic                   m_done_reg, m_done_next;
    logic [TOTAL_W-1:0]     m_total_reg, m_total_next;

    sbm_win_ctrl_t          win_ctrl;
    sbm_win_stat_t          win_stat;

    logic [CNT_W-1:0]       len_act;
    logic [CNT_W-1:0]       fill_dec;
    logic [CNT_W-1:0]       fill_mid;
    logic [IDX_W-1:0]       load_idx;
    logic [TOTAL_W-1:0]     cnt_inc;
    logic                   out_free;
    logic                   adv;
    logic                   act_open;
    logic                   act_byte;
    logic                   act_close;
    logic                   close_follows;
    logic                   more;
    logic                   res_last;
    logic                   in_acc;

    sbm_window u_window (
        .aclk    (aclk),
        .ctrl    (win_ctrl),
        .pattern (pat_reg),
        .stat    (win_stat)
    );

    always_comb begin
        if (plen_reg == 4'd0) begin
            len_act = CNT_W'(1);
        end else if (plen_reg > 4'(MAX_PATTERN)) begin
            len_act = CNT_W'(MAX_PATTERN);
        end else begin
            len_act = CNT_W'(plen_reg);
        end
    end

    assign fill_dec = fill_reg - CNT_W'(1);
    assign cnt_inc  = (cnt_reg == '1) ? cnt_reg : cnt_reg + TOTAL_W'(1);
    assign out_free = !m_valid_reg || m_ready;
    assign adv      = run_reg && out_free;

    assign act_open = (phase_reg == PH_HEAD) && (cd_reg == '0) &&
                      (fill_reg >= len_act) && win_stat.match;
    assign act_byte = ((phase_reg == PH_HEAD) && !act_open) || (phase_reg == PH_BYTE);
    assign act_close = (phase_reg == PH_CLOSE);
    assign close_follows = act_byte && (cd_reg == CNT_W'(1));

    always_comb begin
        if (act_open || close_follows) begin
            more = 1'b1;
        end else if (act_byte) begin
            more = flush_reg ? (fill_dec != '0) : (fill_dec >= len_act);
        end else begin
            more = flush_reg ? (fill_reg != '0) : (fill_reg >= len_act);
        end
    end

    assign res_last = !more;
    assign s_ready  = !run_reg || (adv && res_last && !flush_reg);
    assign in_acc   = s_valid && s_ready;

    assign fill_mid = (adv && act_byte) ? fill_dec : fill_reg;
    assign load_idx = fill_mid[IDX_W-1:0];

    always_comb begin
        win_ctrl.shift = adv && act_byte;
        win_ctrl.data  = s_text_byte;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            win_ctrl.load[i]   = in_acc && (load_idx == IDX_W'(i));
            win_ctrl.in_use[i] = CNT_W'(i) < len_act;
        end
    end

    always_comb begin
        pat_next     = pat_reg;
        plen_next    = plen_reg;
        phase_next   = phase_reg;
        fill_next    = in_acc ? fill_mid + CNT_W'(1) : fill_mid;
        cd_next      = cd_reg;
        cnt_next     = cnt_reg;
        run_next     = run_reg;
        flush_next   = flush_reg;
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_brk_next   = m_brk_reg;
        m_last_next  = m_last_reg;
        m_done_next  = m_done_reg;
        m_total_next = m_total_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PATTERN_BYTES:  pat_next  = cfg_wr_data;
                CFG_PATTERN_LENGTH: plen_next = cfg_wr_data[3:0];
                default: ;
            endcase
        end

        if (out_free) begin
            m_valid_next = adv;
        end

        if (adv) begin
            m_brk_next   = !act_byte;
            m_last_next  = res_last;
            m_done_next  = res_last && flush_reg;
            m_total_next = act_open ? cnt_inc : cnt_reg;
            if (act_open) begin
                m_byte_next = OPEN_CHAR;
                phase_next  = PH_BYTE;
                cd_next     = len_act;
                cnt_next    = cnt_inc;
            end else if (act_byte) begin
                m_byte_next = win_stat.head;
                phase_next  = close_follows ? PH_CLOSE : PH_HEAD;
                if (cd_reg != '0) begin
                    cd_next = cd_reg - CNT_W'(1);
                end
            end else begin
                m_byte_next = CLOSE_CHAR;
                phase_next  = PH_HEAD;
            end
            if (res_last) begin
                run_next = 1'b0;
                if (flush_reg) begin
                    flush_next = 1'b0;
                    cnt_next   = '0;
                    cd_next    = '0;
                end
            end
        end

        if (in_acc) begin
            run_next   = (fill_next >= len_act) || s_text_end;
            flush_next = s_text_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_reg     <= '0;
            plen_reg    <= 4'd1;
            phase_reg   <= PH_HEAD;
            fill_reg    <= '0;
            cd_reg      <= '0;
            cnt_reg     <= '0;
            run_reg     <= 1'b0;
            flush_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pat_reg     <= pat_next;
            plen_reg    <= plen_next;
            phase_reg   <= phase_next;
            fill_reg    <= fill_next;
            cd_reg      <= cd_next;
            cnt_reg     <= cnt_next;
            run_reg     <= run_next;
            flush_reg   <= flush_next;
            m_valid_reg <= m_valid_next;
        end
        m_byte_reg  <= m_byte_next;
        m_brk_reg   <= m_brk_next;
        m_last_reg  <= m_last_next;
        m_done_reg  <= m_done_next;
        m_total_reg <= m_total_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_byte_reg;
    assign m_is_bracket  = m_brk_reg;
    assign m_run_last    = m_last_reg;
    assign m_stream_done = m_done_reg;
    assign m_match_total = m_total_reg;

    // a new item only enters on the last result of the one before
    a_ready_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_ready && run_reg) |-> (adv && res_last && !flush_reg))
        else $error("input taken while results still pending");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(MAX_PATTERN))
        else $error("window fill beyond depth");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && act_open) |-> (cd_reg == '0))
        else $error("match opened inside another match");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_stream_done) |-> m_run_last)
        else $error("stream end not on last result of its transfer");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && res_last && flush_reg) |=> (fill_reg == '0 && cnt_reg == '0 && cd_reg == '0))
        else $error("state not cleared after end of text");

endmodule

### src/sbm_cell.sv
// ----------------------------------------------------------------------------
// sbm_cell
// one window position: holds a text byte, shifts towards the head and
// compares its byte with the pattern byte of the same position
// ----------------------------------------------------------------------------
module sbm_cell
    import sbm_pkg::*;
(
    input  logic       aclk,
    input  logic       shift,
    input  logic       load,
    input  logic [7:0] load_data,
    input  logic [7:0] right_byte,
    input  logic [7:0] pattern_byte,
    input  logic       in_use,
    input  logic       match_in,
    output logic [7:0] byte_out,
    output logic       match_out
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb begin
        if (load) begin
            byte_next = load_data;
        end else if (shift) begin
            byte_next = right_byte;
        end else begin
            byte_next = byte_reg;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign byte_out  = byte_reg;
    assign match_out = match_in && (!in_use || (byte_reg == pattern_byte));

endmodule

### src/sbm_window.sv
// ----------------------------------------------------------------------------
// sbm_window
// row of window cells, oldest byte at the head, with a match chain that
// runs from the far end towards the head
// ----------------------------------------------------------------------------
module sbm_window
    import sbm_pkg::*;
(
    input  logic                       aclk,
    input  sbm_win_ctrl_t              ctrl,
    input  logic [8*MAX_PATTERN-1:0]   pattern,
    output sbm_win_stat_t              stat
);

    logic [7:0] data_row [MAX_PATTERN+1];
    logic       match_row [MAX_PATTERN+1];

    assign data_row[MAX_PATTERN]  = '0;
    assign match_row[MAX_PATTERN] = 1'b1;

    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
        sbm_cell u_cell (
            .aclk         (aclk),
            .shift        (ctrl.shift),
            .load         (ctrl.load[i]),
            .load_data    (ctrl.data),
            .right_byte   (data_row[i+1]),
            .pattern_byte (pattern[8*i +: 8]),
            .in_use       (ctrl.in_use[i]),
            .match_in     (match_row[i+1]),
            .byte_out     (data_row[i]),
            .match_out    (match_row[i])
        );
    end

    assign stat.head  = data_row[0];
    assign stat.match = match_row[0];

endmodule
